>>> hw/rtl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types, constants and helper functions for the SOME/IP header checker.
// ----------------------------------------------------------------------------
package shc_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int HALF_W    = 16;
   localparam int STATUS_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] HEADER_BYTES = 32'd16;
   localparam logic [WORD_W-1:0] MIN_LENGTH   = 32'd8;
   localparam logic [HALF_W-1:0] SERVICE_NONE = 16'h0000;
   localparam logic [HALF_W-1:0] METHOD_NONE  = 16'hFFFF;
   localparam logic [BYTE_W-1:0] RC_MAX       = 8'h0F;

   // header word slots, selected by byte_count[3:2]
   localparam logic [1:0] SLOT_ID      = 2'd0;
   localparam logic [1:0] SLOT_LENGTH  = 2'd1;
   localparam logic [1:0] SLOT_REQUEST = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROTO_VERSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IFACE_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD   = 2'd2;

   localparam logic [BYTE_W-1:0] RST_PROTO_VERSION = 8'd1;
   localparam logic [BYTE_W-1:0] RST_IFACE_VERSION = 8'd1;
   localparam logic [WORD_W-1:0] RST_MAX_PAYLOAD   = 32'd65535;

   // message type codes
   localparam logic [BYTE_W-1:0] MT_REQUEST          = 8'h00;
   localparam logic [BYTE_W-1:0] MT_REQUEST_NO_RET   = 8'h01;
   localparam logic [BYTE_W-1:0] MT_NOTIFICATION     = 8'h02;
   localparam logic [BYTE_W-1:0] MT_TP_REQUEST       = 8'h20;
   localparam logic [BYTE_W-1:0] MT_TP_REQUEST_NORET = 8'h21;
   localparam logic [BYTE_W-1:0] MT_TP_NOTIFICATION  = 8'h22;
   localparam logic [BYTE_W-1:0] MT_REQUEST_ACK      = 8'h40;
   localparam logic [BYTE_W-1:0] MT_RESPONSE         = 8'h80;
   localparam logic [BYTE_W-1:0] MT_ERROR            = 8'h81;
   localparam logic [BYTE_W-1:0] MT_RESPONSE_ACK     = 8'hC0;
   localparam logic [BYTE_W-1:0] MT_ERROR_ACK        = 8'hC1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 4'd0,
      ST_SHORT          = 4'd1,
      ST_LENGTH_SMALL   = 4'd2,
      ST_LENGTH_MISMATCH = 4'd3,
      ST_SERVICE_ZERO   = 4'd4,
      ST_METHOD_NONE    = 4'd5,
      ST_BAD_TYPE       = 4'd6,
      ST_PROTO_VERSION  = 4'd7,
      ST_IFACE_VERSION  = 4'd8,
      ST_NOTIF_RC       = 4'd9,
      ST_RC_RANGE       = 4'd10,
      ST_TOO_BIG        = 4'd11
   } status_type;

   typedef struct packed {
      logic              fire;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } step_type;

   typedef struct packed {
      logic [WORD_W-1:0] byte_count;
      logic [WORD_W-1:0] id_word;
      logic [WORD_W-1:0] length_word;
      logic [WORD_W-1:0] request_word;
      logic [WORD_W-1:0] version_type_code;
   } frame_type;

   typedef struct packed {
      logic [BYTE_W-1:0] proto_version;
      logic [BYTE_W-1:0] iface_version;
      logic [WORD_W-1:0] max_payload;
   } cfg_type;

   function automatic logic type_allowed(input logic [BYTE_W-1:0] mtype);
      logic ok;
      case (mtype)
         MT_REQUEST, MT_REQUEST_NO_RET, MT_NOTIFICATION,
         MT_TP_REQUEST, MT_TP_REQUEST_NORET, MT_TP_NOTIFICATION,
         MT_REQUEST_ACK, MT_RESPONSE, MT_ERROR,
         MT_RESPONSE_ACK, MT_ERROR_ACK: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> hw/rtl/shc_if.sv
// ----------------------------------------------------------------------------
// shc_if
// Valid/ready channel interfaces: frame bytes in, check results out, CSR writes.
// ----------------------------------------------------------------------------
interface shc_req_if;
   logic                        valid;
   logic                        ready;
   logic [shc_pkg::BYTE_W-1:0]  data_byte;
   logic                        last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface shc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [shc_pkg::STATUS_W-1:0]  status;
   logic [shc_pkg::HALF_W-1:0]    svc_id;
   logic [shc_pkg::HALF_W-1:0]    mth_id;
   logic [shc_pkg::WORD_W-1:0]    length_field;
   logic [shc_pkg::HALF_W-1:0]    clt_id;
   logic [shc_pkg::HALF_W-1:0]    sess_id;
   logic [shc_pkg::BYTE_W-1:0]    msg_kind;
   logic [shc_pkg::BYTE_W-1:0]    ret_code;
   logic [shc_pkg::WORD_W-1:0]    payload_bytes;
   modport source (output valid, status, svc_id, mth_id, length_field, clt_id,
                   sess_id, msg_kind, ret_code, payload_bytes, input ready);
   modport sink   (input valid, status, svc_id, mth_id, length_field, clt_id,
                   sess_id, msg_kind, ret_code, payload_bytes, output ready);
endinterface

interface shc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [shc_pkg::CSR_IDX_W-1:0]  index;
   logic [shc_pkg::WORD_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/someip_header_checker_unit.sv
// ----------------------------------------------------------------------------
// someip_header_checker_unit
// Byte-serial SOME/IP header capture and check, one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch : one frame byte per word, last_byte set on the final byte.
//   rsp_ch : one word per frame with status, header fields and payload count.
//   csr_ch : register writes (0 protocol version, 1 interface version,
//            2 max payload); always ready, write only while idle.
// Throughput: one byte per cycle; the input register and the result register
//   each hold one word, and the per-byte work is a counter and a header shift.
// Result path: a last byte is held in the input register, then goes through the
//   check logic into the result register that drives the result word.
// Reset: clears the byte counter, header words and both valid flags, and loads
//   the register defaults (versions 1, payload limit 65535).
// Stall: while rsp_ch is held, payload bytes keep flowing; a last byte waits
//   in the input register with req_ch.ready low until the result slot frees.
// ----------------------------------------------------------------------------
module someip_header_checker_unit (
   input  logic       clock,
   input  logic       reset,
   shc_req_if.sink    req_ch,
   shc_rsp_if.source  rsp_ch,
   shc_csr_if.sink    csr_ch
);
   import shc_pkg::*;

   step_type  step;
   frame_type view;
   cfg_type   cfg;
   logic      out_free;

   shc_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   shc_input_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .step     (step)
   );

   shc_frame_tracker u_trk (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .view  (view)
   );

   shc_judge u_jdg (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .view     (view),
      .cfg      (cfg),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> hw/rtl/shc_csr_regs.sv
// ----------------------------------------------------------------------------
// shc_csr_regs
// Configuration registers: expected versions and payload limit.
// ----------------------------------------------------------------------------
module shc_csr_regs (
   input  logic              clock,
   input  logic              reset,
   shc_csr_if.sink           csr_ch,
   output shc_pkg::cfg_type  cfg
);
   import shc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PROTO_VERSION: cfg_in.proto_version = csr_ch.data[BYTE_W-1:0];
            CSR_IFACE_VERSION: cfg_in.iface_version = csr_ch.data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD:   cfg_in.max_payload   = csr_ch.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proto_version <= RST_PROTO_VERSION;
         cfg_ff.iface_version <= RST_IFACE_VERSION;
         cfg_ff.max_payload   <= RST_MAX_PAYLOAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/shc_input_stage.sv
// ----------------------------------------------------------------------------
// shc_input_stage
// Input register for frame bytes; only a last byte waits for the result slot.
// ----------------------------------------------------------------------------
module shc_input_stage (
   input  logic               clock,
   input  logic               reset,
   shc_req_if.sink            req_ch,
   input  logic               out_free,
   output shc_pkg::step_type  step
);
   import shc_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic              advance;
   logic              take;

   assign advance      = valid_ff && (!last_ff || out_free);
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_ch.data_byte;
         last_ff <= req_ch.last_byte;
      end
   end

   assign step.fire      = advance;
   assign step.data_byte = byte_ff;
   assign step.last_byte = last_ff;

endmodule

>>> hw/rtl/shc_frame_tracker.sv
// ----------------------------------------------------------------------------
// shc_frame_tracker
// Byte counter and header word capture; shows the frame state after this word.
// ----------------------------------------------------------------------------
module shc_frame_tracker (
   input  logic               clock,
   input  logic               reset,
   input  shc_pkg::step_type  step,
   output shc_pkg::frame_type view
);
   import shc_pkg::*;

   frame_type frame_ff, frame_in;

   always_comb begin
      view = frame_ff;
      if (frame_ff.byte_count < HEADER_BYTES) begin
         case (frame_ff.byte_count[3:2])
            SLOT_ID:      view.id_word      = {frame_ff.id_word[23:0], step.data_byte};
            SLOT_LENGTH:  view.length_word  = {frame_ff.length_word[23:0], step.data_byte};
            SLOT_REQUEST: view.request_word = {frame_ff.request_word[23:0], step.data_byte};
            default:      view.version_type_code =
                             {frame_ff.version_type_code[23:0], step.data_byte};
         endcase
      end
      if (frame_ff.byte_count != '1) begin
         view.byte_count = frame_ff.byte_count + 32'd1;
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (step.fire) begin
         frame_in = step.last_byte ? '0 : view;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

endmodule

>>> hw/rtl/shc_judge.sv
// ----------------------------------------------------------------------------
// shc_judge
// Ordered header checks and the result register that drives the output channel.
// ----------------------------------------------------------------------------
module shc_judge (
   input  logic                clock,
   input  logic                reset,
   input  shc_pkg::step_type   step,
   input  shc_pkg::frame_type  view,
   input  shc_pkg::cfg_type    cfg,
   output logic                out_free,
   shc_rsp_if.source           rsp_ch
);
   import shc_pkg::*;

   logic              valid_ff, valid_in;
   logic              load;
   logic [WORD_W-1:0] payload;
   logic [WORD_W:0]   expected_len;
   logic [BYTE_W-1:0] mtype, rc;
   status_type        status;

   logic [STATUS_W-1:0] status_ff;
   logic [WORD_W-1:0]   id_ff, length_ff, request_ff, payload_ff;
   logic [HALF_W-1:0]   type_rc_ff;

   assign mtype        = view.version_type_code[15:8];
   assign rc           = view.version_type_code[7:0];
   assign payload      = (view.byte_count >= HEADER_BYTES) ?
                         (view.byte_count - HEADER_BYTES) : '0;
   assign expected_len = {1'b0, payload} + {1'b0, MIN_LENGTH};

   always_comb begin
      if (view.byte_count < HEADER_BYTES) begin
         status = ST_SHORT;
      end else if (view.length_word < MIN_LENGTH) begin
         status = ST_LENGTH_SMALL;
      end else if ({1'b0, view.length_word} != expected_len) begin
         status = ST_LENGTH_MISMATCH;
      end else if (view.id_word[31:16] == SERVICE_NONE) begin
         status = ST_SERVICE_ZERO;
      end else if (view.id_word[15:0] == METHOD_NONE) begin
         status = ST_METHOD_NONE;
      end else if (!type_allowed(mtype)) begin
         status = ST_BAD_TYPE;
      end else if (view.version_type_code[31:24] != cfg.proto_version) begin
         status = ST_PROTO_VERSION;
      end else if (view.version_type_code[23:16] != cfg.iface_version) begin
         status = ST_IFACE_VERSION;
      end else if ((mtype == MT_NOTIFICATION || mtype == MT_TP_NOTIFICATION) && rc != '0) begin
         status = ST_NOTIF_RC;
      end else if (rc > RC_MAX) begin
         status = ST_RC_RANGE;
      end else if (payload > cfg.max_payload) begin
         status = ST_TOO_BIG;
      end else begin
         status = ST_OK;
      end
   end

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load     = step.fire && step.last_byte;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status;
         id_ff      <= view.id_word;
         length_ff  <= view.length_word;
         request_ff <= view.request_word;
         type_rc_ff <= view.version_type_code[15:0];
         payload_ff <= payload;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.svc_id        = id_ff[31:16];
   assign rsp_ch.mth_id        = id_ff[15:0];
   assign rsp_ch.length_field  = length_ff;
   assign rsp_ch.clt_id        = request_ff[31:16];
   assign rsp_ch.sess_id       = request_ff[15:0];
   assign rsp_ch.msg_kind      = type_rc_ff[15:8];
   assign rsp_ch.ret_code      = type_rc_ff[7:0];
   assign rsp_ch.payload_bytes = payload_ff;

endmodule

>>> hw/rtl/shc_checker.sv
// ----------------------------------------------------------------------------
// shc_checker
// Port-level assertions for the header checker, bound to the top level.
// ----------------------------------------------------------------------------
module shc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [shc_pkg::STATUS_W-1:0]  status,
   input logic [shc_pkg::HALF_W-1:0]    svc_id,
   input logic [shc_pkg::HALF_W-1:0]    mth_id,
   input logic [shc_pkg::WORD_W-1:0]    length_field,
   input logic [shc_pkg::BYTE_W-1:0]    ret_code,
   input logic [shc_pkg::WORD_W-1:0]    payload_bytes
);
   import shc_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(payload_bytes))
      else $error("stalled result changed");

   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_OK |->
         ({1'b0, length_field} == {1'b0, payload_bytes} + 33'd8) &&
         svc_id != SERVICE_NONE && mth_id != METHOD_NONE && ret_code <= RC_MAX)
      else $error("ok status with failing header");

   a_short_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_SHORT |-> payload_bytes == '0)
      else $error("short frame with payload");

endmodule

bind someip_header_checker_unit shc_checker u_shc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .svc_id        (rsp_ch.svc_id),
   .mth_id        (rsp_ch.mth_id),
   .length_field  (rsp_ch.length_field),
   .ret_code      (rsp_ch.ret_code),
   .payload_bytes (rsp_ch.payload_bytes)
);

>>> tb/shc_header_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shc_header_monitor
// Watches the byte, result and register channels of the header checker. It
// keeps its own copy of the header capture and register state, works out the
// verdict for every frame, and compares each result word field by field.
// ----------------------------------------------------------------------------
module shc_header_monitor (
   input  logic clock,
   input  logic reset,
   shc_req_if   req_ch,
   shc_rsp_if   rsp_ch,
   shc_csr_if   csr_ch,
   output int   fault_count,
   output int   frames_in_flight
);
   import shc_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [HALF_W-1:0] svc_id;
      logic [HALF_W-1:0] mth_id;
      logic [WORD_W-1:0] length_field;
      logic [HALF_W-1:0] clt_id;
      logic [HALF_W-1:0] sess_id;
      logic [BYTE_W-1:0] msg_kind;
      logic [BYTE_W-1:0] ret_code;
      logic [WORD_W-1:0] payload_bytes;
   } report_type;

   report_type    pending_reports[$];
   frame_type     capture;
   cfg_type       limits;
   int            faults = 0;

   assign fault_count = faults;

   function automatic logic known_msg_type(logic [BYTE_W-1:0] mtype);
      return mtype inside {MT_REQUEST, MT_REQUEST_NO_RET, MT_NOTIFICATION, MT_TP_REQUEST,
                           MT_TP_REQUEST_NORET, MT_TP_NOTIFICATION, MT_REQUEST_ACK,
                           MT_RESPONSE, MT_ERROR, MT_RESPONSE_ACK, MT_ERROR_ACK};
   endfunction

   // first failing check wins
   function automatic status_type grade_frame(frame_type f, cfg_type c,
                                              logic [WORD_W-1:0] payload);
      logic [BYTE_W-1:0] mtype;
      logic [BYTE_W-1:0] rc;
      mtype = f.version_type_code[15:8];
      rc    = f.version_type_code[7:0];
      if (f.byte_count < HEADER_BYTES) return ST_SHORT;
      if (f.length_word < MIN_LENGTH) return ST_LENGTH_SMALL;
      if ({1'b0, f.length_word} != {1'b0, payload} + {1'b0, MIN_LENGTH})
         return ST_LENGTH_MISMATCH;
      if (f.id_word[31:16] == SERVICE_NONE) return ST_SERVICE_ZERO;
      if (f.id_word[15:0] == METHOD_NONE) return ST_METHOD_NONE;
      if (!known_msg_type(mtype)) return ST_BAD_TYPE;
      if (f.version_type_code[31:24] != c.proto_version) return ST_PROTO_VERSION;
      if (f.version_type_code[23:16] != c.iface_version) return ST_IFACE_VERSION;
      if ((mtype == MT_NOTIFICATION || mtype == MT_TP_NOTIFICATION) && rc != 8'h00)
         return ST_NOTIF_RC;
      if (rc > RC_MAX) return ST_RC_RANGE;
      if (payload > c.max_payload) return ST_TOO_BIG;
      return ST_OK;
   endfunction

   task automatic take_byte(logic [BYTE_W-1:0] b, logic last);
      report_type        r;
      logic [WORD_W-1:0] payload;
      if (capture.byte_count < HEADER_BYTES) begin
         case (capture.byte_count[3:2])
            SLOT_ID:      capture.id_word      = {capture.id_word[23:0], b};
            SLOT_LENGTH:  capture.length_word  = {capture.length_word[23:0], b};
            SLOT_REQUEST: capture.request_word = {capture.request_word[23:0], b};
            default:      capture.version_type_code = {capture.version_type_code[23:0], b};
         endcase
      end
      if (capture.byte_count != '1) capture.byte_count = capture.byte_count + 1;
      if (last) begin
         payload = (capture.byte_count >= HEADER_BYTES) ?
                   capture.byte_count - HEADER_BYTES : '0;
         r.status        = grade_frame(capture, limits, payload);
         r.svc_id        = capture.id_word[31:16];
         r.mth_id        = capture.id_word[15:0];
         r.length_field  = capture.length_word;
         r.clt_id        = capture.request_word[31:16];
         r.sess_id       = capture.request_word[15:0];
         r.msg_kind      = capture.version_type_code[15:8];
         r.ret_code      = capture.version_type_code[7:0];
         r.payload_bytes = payload;
         pending_reports = {pending_reports, r};
         capture = '0;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         faults++;
         if (faults <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   task automatic match_result();
      report_type want;
      if (pending_reports.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("%0t: unexpected result word, status %h", $time, rsp_ch.status);
      end else begin
         want = pending_reports.pop_front();
         check_field("status", 32'(want.status), 32'(rsp_ch.status));
         check_field("svc_id", 32'(want.svc_id), 32'(rsp_ch.svc_id));
         check_field("mth_id", 32'(want.mth_id), 32'(rsp_ch.mth_id));
         check_field("length_field", want.length_field, rsp_ch.length_field);
         check_field("clt_id", 32'(want.clt_id), 32'(rsp_ch.clt_id));
         check_field("sess_id", 32'(want.sess_id), 32'(rsp_ch.sess_id));
         check_field("msg_kind", 32'(want.msg_kind), 32'(rsp_ch.msg_kind));
         check_field("ret_code", 32'(want.ret_code), 32'(rsp_ch.ret_code));
         check_field("payload_bytes", want.payload_bytes, rsp_ch.payload_bytes);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capture = '0;
         limits  = {RST_PROTO_VERSION, RST_IFACE_VERSION, RST_MAX_PAYLOAD};
         pending_reports.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_PROTO_VERSION: limits.proto_version = csr_ch.data[BYTE_W-1:0];
               CSR_IFACE_VERSION: limits.iface_version = csr_ch.data[BYTE_W-1:0];
               CSR_MAX_PAYLOAD:   limits.max_payload   = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) take_byte(req_ch.data_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready) match_result();
      end
      frames_in_flight <= pending_reports.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives SOME/IP frames into the header checker a byte per word: a directed
// set for every check, then random phases under several register settings
// with bursty input, stalled output and one long hold.
// ----------------------------------------------------------------------------
module tb_top;
   import shc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 200;
   localparam logic [BYTE_W-1:0] MSG_KINDS [11] = '{
      MT_REQUEST, MT_REQUEST_NO_RET, MT_NOTIFICATION, MT_TP_REQUEST, MT_TP_REQUEST_NORET,
      MT_TP_NOTIFICATION, MT_REQUEST_ACK, MT_RESPONSE, MT_ERROR, MT_RESPONSE_ACK,
      MT_ERROR_ACK};

   typedef enum logic [1:0] {RSP_STEADY, RSP_RANDOM, RSP_PATTERN} rsp_style_type;

   typedef struct {
      logic [HALF_W-1:0] service;
      logic [HALF_W-1:0] method;
      logic [WORD_W-1:0] length;
      logic [HALF_W-1:0] client;
      logic [HALF_W-1:0] session;
      logic [BYTE_W-1:0] proto;
      logic [BYTE_W-1:0] iface;
      logic [BYTE_W-1:0] mtype;
      logic [BYTE_W-1:0] rc;
      int unsigned       total;
   } frame_msg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shc_req_if frame_bus ();
   shc_rsp_if verdict_bus ();
   shc_csr_if csr_bus ();

   int fault_count;
   int frames_in_flight;
   int quiet_cycles = 0;

   logic [BYTE_W-1:0] cur_proto = RST_PROTO_VERSION;
   logic [BYTE_W-1:0] cur_iface = RST_IFACE_VERSION;
   logic [WORD_W-1:0] cur_max   = RST_MAX_PAYLOAD;
   int                gap_max   = 5;
   int                burst_left = 0;
   int unsigned       bytes_sent = 0;
   int unsigned       frames_sent = 0;
   rsp_style_type     rsp_mode  = RSP_RANDOM;
   int                hold_seq  = 0;

   someip_header_checker_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (frame_bus),
      .rsp_ch (verdict_bus),
      .csr_ch (csr_bus)
   );

   shc_header_monitor frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (frame_bus),
      .rsp_ch           (verdict_bus),
      .csr_ch           (csr_bus),
      .fault_count      (fault_count),
      .frames_in_flight (frames_in_flight)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (frame_bus.valid && frame_bus.ready) ||
          (verdict_bus.valid && verdict_bus.ready) || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: own stall pattern, plus the long hold when asked
   initial begin
      int hold_cnt;
      int hold_seen;
      int tick;
      hold_cnt  = 0;
      hold_seen = 0;
      tick      = 0;
      verdict_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_cnt  = LONG_HOLD;
         end
         if (reset) begin
            verdict_bus.ready <= 1'b0;
         end else if (hold_cnt != 0) begin
            hold_cnt--;
            verdict_bus.ready <= 1'b0;
         end else begin
            case (rsp_mode)
               RSP_STEADY: verdict_bus.ready <= 1'b1;
               RSP_RANDOM: verdict_bus.ready <= ($urandom_range(0, 99) < 60);
               default:    verdict_bus.ready <= ((tick % 7) > 2);
            endcase
         end
      end
   end

   function automatic frame_msg_type good_message(int unsigned payload_n);
      frame_msg_type m;
      if (payload_n > cur_max) payload_n = cur_max;
      m.service = 16'($urandom_range(1, 16'hFFFF));
      m.method  = 16'($urandom_range(0, 16'hFFFE));
      m.length  = payload_n + MIN_LENGTH;
      m.client  = 16'($urandom);
      m.session = 16'($urandom);
      m.proto   = cur_proto;
      m.iface   = cur_iface;
      m.mtype   = MSG_KINDS[$urandom_range(0, 10)];
      m.rc      = (m.mtype == MT_NOTIFICATION || m.mtype == MT_TP_NOTIFICATION) ?
                  8'h00 : 8'($urandom_range(0, 32'(RC_MAX)));
      m.total   = HEADER_BYTES + payload_n;
      return m;
   endfunction

   task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            frame_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      frame_bus.valid     <= 1'b1;
      frame_bus.data_byte <= b;
      frame_bus.last_byte <= last;
      do @(posedge clock); while (!frame_bus.ready);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_message(frame_msg_type m);
      logic [127:0] hdr;
      hdr = {m.service, m.method, m.length, m.client, m.session,
             m.proto, m.iface, m.mtype, m.rc};
      for (int unsigned i = 0; i < m.total; i++)
         send_byte((i < HEADER_BYTES) ? hdr[127 - 8*i -: 8] : 8'($urandom),
                   i == m.total - 1);
      frames_sent++;
   endtask

   // mostly well-formed frames, the rest with one or two fields broken
   task automatic random_message();
      frame_msg_type m;
      int unsigned   pn;
      int unsigned   extra;
      pn = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      m = good_message(pn);
      if ($urandom_range(0, 99) < 35) begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 9))
               0: m.total = $urandom_range(1, 15);
               1: m.length = $urandom_range(0, 7);
               2: m.length = m.length ^ (32'h1 << $urandom_range(0, 31));
               3: m.service = SERVICE_NONE;
               4: m.method = METHOD_NONE;
               5: m.mtype = 8'($urandom);
               6: m.proto = 8'($urandom);
               7: m.iface = 8'($urandom);
               8: m.rc = 8'($urandom);
               default: begin
                  extra = $urandom_range(1, 6);
                  m.total  = m.total + extra;
                  m.length = m.length + extra;
               end
            endcase
         end
      end
      send_message(m);
   endtask

   task automatic settle();
      frame_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (frames_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(logic [BYTE_W-1:0] proto, logic [BYTE_W-1:0] iface,
                              logic [WORD_W-1:0] max_pl);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [WORD_W-1:0]    vals [3];
      idx  = '{CSR_PROTO_VERSION, CSR_IFACE_VERSION, CSR_MAX_PAYLOAD};
      vals = '{32'(proto), 32'(iface), max_pl};
      for (int k = 0; k < 3; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[k];
         csr_bus.data  <= vals[k];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cur_proto = proto;
      cur_iface = iface;
      cur_max   = max_pl;
   endtask

   initial begin
      frame_msg_type m;
      int unsigned   mark_bytes;
      int unsigned   mark_frames;
      frame_bus.valid     <= 1'b0;
      frame_bus.data_byte <= '0;
      frame_bus.last_byte <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= '0;
      csr_bus.data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset register values
      m = good_message(0); send_message(m);
      m = good_message(5); m.mtype = MT_NOTIFICATION; m.rc = 8'h00; send_message(m);
      m = good_message(0); m.total = 1; send_message(m);
      m = good_message(0); m.total = 15; send_message(m);
      m = good_message(0); m.length = '0; send_message(m);
      m = good_message(0); m.length = 32'd7; send_message(m);
      m = good_message(3); m.length = '1; send_message(m);
      m = good_message(0); m.length = 32'd9; send_message(m);
      m = good_message(2); m.length = 32'd8; send_message(m);
      m = good_message(1); m.service = SERVICE_NONE; send_message(m);
      m = good_message(1); m.service = 16'hFFFF; m.method = 16'hFFFE;
      m.client = 16'hFFFF; m.session = 16'hFFFF; send_message(m);
      m = good_message(0); m.method = METHOD_NONE; send_message(m);
      m = good_message(0); m.service = SERVICE_NONE; m.method = METHOD_NONE; send_message(m);
      m = good_message(0); m.mtype = 8'h03; send_message(m);
      m = good_message(0); m.mtype = 8'hFF; send_message(m);
      m = good_message(0); m.proto = 8'h02; send_message(m);
      m = good_message(0); m.iface = 8'h00; send_message(m);
      m = good_message(0); m.mtype = MT_NOTIFICATION; m.rc = 8'h01; send_message(m);
      m = good_message(0); m.mtype = MT_TP_NOTIFICATION; m.rc = RC_MAX; send_message(m);
      m = good_message(0); m.mtype = MT_RESPONSE; m.rc = 8'h10; send_message(m);
      m = good_message(0); m.mtype = MT_ERROR; m.rc = 8'hFF; send_message(m);
      settle();

      load_config(8'h00, 8'hFF, 32'h0);
      m = good_message(0); m.total = HEADER_BYTES + 1; m.length = 32'd9; send_message(m);
      m = good_message(0); send_message(m);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               gap_max  = 6;
               rsp_mode <= RSP_RANDOM;
            end
            1: begin
               settle();
               load_config(8'hFF, 8'h00, 32'hFFFF_FFFF);
               gap_max  = 0;
               rsp_mode <= RSP_STEADY;
            end
            2: begin
               settle();
               load_config(8'($urandom), 8'($urandom), $urandom_range(0, 16));
               gap_max  = 3;
               rsp_mode <= RSP_PATTERN;
               hold_seq <= hold_seq + 1;
            end
            3: begin
               settle();
               load_config(8'($urandom), 8'($urandom), RST_MAX_PAYLOAD);
               gap_max  = 10;
               rsp_mode <= RSP_RANDOM;
            end
            default: begin
               settle();
               load_config(8'($urandom), 8'($urandom), $urandom_range(0, 40));
               gap_max  = 4;
               rsp_mode <= RSP_PATTERN;
            end
         endcase
         mark_bytes  = bytes_sent;
         mark_frames = frames_sent;
         while (bytes_sent - mark_bytes < 70 || frames_sent - mark_frames < 3)
            random_message();
      end

      settle();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && frames_in_flight == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/shc_pkg.sv
hw/rtl/shc_if.sv
hw/rtl/shc_csr_regs.sv
hw/rtl/shc_input_stage.sv
hw/rtl/shc_frame_tracker.sv
hw/rtl/shc_judge.sv
hw/rtl/someip_header_checker_unit.sv
hw/rtl/shc_checker.sv
tb/shc_header_monitor.sv
tb/tb_top.sv
